>>> hdl/hfl_pkg.sv
// Shared types, constants and helper functions for the HTTP header field locator.
// Used by hfl_scan and http_header_field_locator; depends on nothing else.
package hfl_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_PAYLOAD = 2048;
  localparam int POS_W       = 12;
  localparam int PLEN_W      = 4;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int CRLF_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8 * MAX_PATTERN;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_BYTE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] PATTERN_RESET = '0;
  localparam logic [PLEN_W-1:0]     PAT_LEN_RESET = 4'd6;
  localparam logic [7:0]            TERM_RESET    = 8'h0D;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [CRLF_W-1:0] CRLF_DONE = 3'd4;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_FOUND   = 2'd1,
    VERDICT_PARTIAL = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern;
    logic [PLEN_W-1:0]     used_len;
    byte_t                 term;
  } hfl_cfg_t;

  typedef struct packed {
    logic       truncated;
    logic [POS_W-1:0] value_length;
    logic [POS_W-1:0] value_offset;
    verdict_t   verdict;
  } hfl_result_t;

  function automatic byte_t lower_ascii(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Pattern length saturated to 1..MAX_PATTERN.
  function automatic logic [PLEN_W-1:0] used_length(input logic [PLEN_W-1:0] len);
    logic [PLEN_W-1:0] r;
    r = len;
    if (len == '0) begin
      r = PLEN_W'(1);
    end else if (len > PLEN_W'(MAX_PATTERN)) begin
      r = PLEN_W'(MAX_PATTERN);
    end
    return r;
  endfunction

endpackage

>>> hdl/hfl_scan.sv
// Per-payload scan state: byte window, CR LF CR LF detector, pattern match and value counter.
// Depends on hfl_pkg; one byte is consumed per step and the verdict is formed in the same cycle.
module hfl_scan import hfl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  byte_t       data_byte,
  input  logic        last_byte,
  input  hfl_cfg_t    cfg,
  output hfl_result_t result
);

  byte_t              win_r   [MAX_PATTERN];
  byte_t              win_nxt [MAX_PATTERN];
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CRLF_W-1:0]  crlf_r, crlf_nxt;
  logic [POS_W-1:0]   hend_r, hend_nxt;
  logic               hseen_r, hseen_nxt;
  logic               match_r, match_nxt;
  logic [POS_W-1:0]   vstart_r, vstart_nxt;
  logic [POS_W-1:0]   vcount_r, vcount_nxt;
  logic               tseen_r, tseen_nxt;
  logic               prefix_r, prefix_nxt;
  logic               ovf_r, ovf_nxt;

  logic [POS_W-1:0]   n_ext;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   start;
  logic               win_eq;
  logic [PLEN_W-1:0]  pidx;

  assign n_ext   = POS_W'(cfg.used_len);
  assign pos_inc = pos_r + POS_W'(1);
  assign start   = pos_inc - n_ext;

  always_comb begin
    win_nxt[0] = data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // The newest byte sits at window index 0, so window index j holds pattern char n-1-j.
  always_comb begin
    win_eq = 1'b1;
    pidx   = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = cfg.used_len - PLEN_W'(1) - PLEN_W'(j);
      if (PLEN_W'(j) < cfg.used_len &&
          win_nxt[j] != cfg.pattern[8*pidx[WIN_IDX_W-1:0] +: 8]) begin
        win_eq = 1'b0;
      end
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    crlf_nxt   = crlf_r;
    hend_nxt   = hend_r;
    hseen_nxt  = hseen_r;
    match_nxt  = match_r;
    vstart_nxt = vstart_r;
    vcount_nxt = vcount_r;
    tseen_nxt  = tseen_r;
    prefix_nxt = prefix_r;
    ovf_nxt    = ovf_r;

    if (pos_r >= POS_W'(MAX_PAYLOAD)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (pos_r < n_ext &&
          lower_ascii(data_byte) != lower_ascii(cfg.pattern[8*pos_r[WIN_IDX_W-1:0] +: 8])) begin
        prefix_nxt = 1'b0;
      end

      if (match_r && !tseen_r) begin
        if (data_byte == cfg.term) begin
          tseen_nxt = 1'b1;
        end else begin
          vcount_nxt = vcount_r + POS_W'(1);
        end
      end

      if (!hseen_r) begin
        if (data_byte == CHAR_CR) begin
          crlf_nxt = crlf_r[0] ? '0 : crlf_r + CRLF_W'(1);
        end else if (data_byte == CHAR_LF) begin
          crlf_nxt = crlf_r[0] ? crlf_r + CRLF_W'(1) : '0;
        end else begin
          crlf_nxt = '0;
        end
        if (crlf_nxt >= CRLF_DONE) begin
          hseen_nxt = 1'b1;
          hend_nxt  = pos_r;
        end
      end

      if (!match_r && pos_inc >= n_ext) begin
        if ((!hseen_nxt || start < hend_nxt) && win_eq) begin
          match_nxt  = 1'b1;
          vstart_nxt = pos_inc;
        end
      end

      pos_nxt = pos_inc;
    end
  end

  always_comb begin
    result.verdict      = VERDICT_NONE;
    result.value_offset = '0;
    result.value_length = '0;
    result.truncated    = ovf_nxt;
    if (pos_nxt == '0) begin
      result.verdict = VERDICT_NONE;
    end else if (pos_nxt <= n_ext) begin
      result.verdict = prefix_nxt ? VERDICT_PARTIAL : VERDICT_NONE;
    end else if (match_nxt) begin
      result.value_offset = vstart_nxt;
      if (tseen_nxt) begin
        result.verdict      = VERDICT_FOUND;
        result.value_length = vcount_nxt;
      end else begin
        result.verdict = VERDICT_PARTIAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // The last byte of a payload returns every scan register but the byte window to its idle value.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r    <= '0;
      crlf_r   <= '0;
      hend_r   <= '0;
      hseen_r  <= 1'b0;
      match_r  <= 1'b0;
      vstart_r <= '0;
      vcount_r <= '0;
      tseen_r  <= 1'b0;
      prefix_r <= 1'b1;
      ovf_r    <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      crlf_r   <= crlf_nxt;
      hend_r   <= hend_nxt;
      hseen_r  <= hseen_nxt;
      match_r  <= match_nxt;
      vstart_r <= vstart_nxt;
      vcount_r <= vcount_nxt;
      tseen_r  <= tseen_nxt;
      prefix_r <= prefix_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

>>> hdl/http_header_field_locator.sv
// Top level of the HTTP header field locator: stream ports, configuration registers,
// input and result registers around the hfl_scan update logic. Depends on hfl_pkg and hfl_scan.

// The block takes one payload byte per clock cycle and never stalls the input on its own;
// it only holds in_tready low when a verdict is pending and the result register is still
// occupied. Each byte is captured in an input register and then processed by a single update
// stage, which a byte that ends a payload enters only once the result register is free; its
// verdict is then registered for output. One result transfer is made per payload, on its last
// byte. A payload ends when in_tlast is high; bytes past the 2048-byte limit are dropped and
// reported through the truncated flag. Configuration writes take effect at once and should
// be made between payloads.
module http_header_field_locator import hfl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [1:0] verdict, [13:2] value_offset,
                                            // [25:14] value_length, [26] truncated

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] pattern_r;
  logic [PLEN_W-1:0]     pat_len_r;
  byte_t                 term_r;

  logic        s0_valid_r, s0_valid_nxt;
  byte_t       s0_byte_r;
  logic        s0_last_r;
  logic        out_valid_r, out_valid_nxt;
  hfl_result_t out_res_r;

  logic        in_xfer;
  logic        out_free;
  logic        proc;
  hfl_cfg_t    cfg;
  hfl_result_t scan_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PATTERN_RESET;
      pat_len_r <= PAT_LEN_RESET;
      term_r    <= TERM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:   pattern_r <= cfg_wdata;
        CFG_PATTERN_LENGTH:  pat_len_r <= cfg_wdata[PLEN_W-1:0];
        CFG_TERMINATOR_BYTE: term_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern  = pattern_r;
  assign cfg.used_len = used_length(pat_len_r);
  assign cfg.term     = term_r;

  // A byte that ends a payload waits until the result register can take its verdict.
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s0_valid_r && (!s0_last_r || out_free);
  assign in_tready = !s0_valid_r || proc;
  assign in_xfer   = in_tvalid && in_tready;

  assign s0_valid_nxt  = in_xfer ? 1'b1 : (proc ? 1'b0 : s0_valid_r);
  assign out_valid_nxt = (proc && s0_last_r) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_byte_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
    if (proc && s0_last_r) begin
      out_res_r <= scan_res;
    end
  end

  hfl_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .data_byte (s0_byte_r),
    .last_byte (s0_last_r),
    .cfg       (cfg),
    .result    (scan_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  // A verdict never takes the unused code.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("verdict holds an unused code");

  // No match means neither an offset nor a length.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == VERDICT_NONE) |-> out_tdata[25:2] == '0)
    else $error("no-match verdict carries offset or length");

  // A partial verdict never carries a value length.
  a_partial_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == VERDICT_PARTIAL) |-> out_tdata[25:14] == '0)
    else $error("partial verdict carries a value length");

  // A byte held back by a pending verdict stays in the input register unchanged.
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !proc) |=> (s0_valid_r && $stable(s0_byte_r) && $stable(s0_last_r)))
    else $error("stalled input byte was lost or changed");

endmodule

>>> verif/tb_http_header_field_locator.sv
// Self-checking testbench for http_header_field_locator: directed rows, then random payloads
// checked against an in-bench model of the pattern search, header-end and terminator logic.
// Depends on hfl_pkg and the RTL only.
module tb_http_header_field_locator;
  timeunit 1ns;
  timeprecision 1ps;
  import hfl_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1100;
  localparam logic [3:0] LEN_EDGES [4] = '{4'd0, 4'd1, 4'd8, 4'd15};

  typedef struct {
    logic                  is_cfg;   // 1: register write, 0: payload byte
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    byte_t                 data;
    logic                  last;
    logic                  typed;    // 1: use the result written in the row
    hfl_result_t           want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Register copies kept by the bench.
  logic [63:0] cfg_pattern;
  logic [3:0]  cfg_len;
  byte_t       cfg_term;

  // Per-payload scan state.
  byte_t win [MAX_PATTERN];
  int    byte_pos;
  int    crlf_run;
  int    hdr_end_at;
  bit    hdr_end_seen;
  bit    field_hit;
  int    field_start;
  int    field_len;
  bit    term_hit;
  bit    prefix_ok;
  bit    over_limit;

  hfl_result_t pending_verdicts[$];
  byte_t       frame_bytes[$];
  stim_row_t   directed_rows[$];
  int          mismatches;
  int          idle_cycles;
  int          burst_left;
  int          random_bytes;
  logic [15:0] stall_pat;
  logic [3:0]  ready_tick;

  http_header_field_locator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_len();
    if (cfg_len == 4'd0) return 1;
    if (cfg_len > 4'(MAX_PATTERN)) return MAX_PATTERN;
    return int'(cfg_len);
  endfunction

  function automatic byte_t pat_char(input int q);
    if (q >= 8) return 8'h00;
    return cfg_pattern[8*q +: 8];
  endfunction

  function automatic byte_t fold_case(input byte_t c);
    if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
    return c;
  endfunction

  function automatic void clear_scan();
    foreach (win[k]) win[k] = 8'h00;
    byte_pos     = 0;
    crlf_run     = 0;
    hdr_end_at   = 0;
    hdr_end_seen = 1'b0;
    field_hit    = 1'b0;
    field_start  = 0;
    field_len    = 0;
    term_hit     = 1'b0;
    prefix_ok    = 1'b1;
    over_limit   = 1'b0;
  endfunction

  // Advances the scan by one byte; returns 1 with the verdict when the byte ends a payload.
  function automatic bit scan_byte(input byte_t b, input logic last, output hfl_result_t res);
    int p;
    int n;
    int start;
    bit same;
    res = '0;
    if (byte_pos >= MAX_PAYLOAD) begin
      over_limit = 1'b1;
    end else begin
      p = byte_pos;
      n = eff_len();
      if (p < n && fold_case(b) != fold_case(pat_char(p))) prefix_ok = 1'b0;
      if (field_hit && !term_hit) begin
        if (b == cfg_term) term_hit = 1'b1;
        else field_len++;
      end
      for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = b;
      if (!hdr_end_seen) begin
        if (b == CHAR_CR) crlf_run = (crlf_run % 2 == 1) ? 0 : crlf_run + 1;
        else if (b == CHAR_LF) crlf_run = (crlf_run % 2 == 1) ? crlf_run + 1 : 0;
        else crlf_run = 0;
        if (crlf_run >= 4) begin
          hdr_end_seen = 1'b1;
          hdr_end_at   = p;
        end
      end
      // The match must start before the header end, once that end is known.
      if (!field_hit && p + 1 >= n) begin
        start = p + 1 - n;
        if (!hdr_end_seen || start < hdr_end_at) begin
          same = 1'b1;
          for (int k = 0; k < n; k++) begin
            if (win[n-1-k] != pat_char(k)) same = 1'b0;
          end
          if (same) begin
            field_hit   = 1'b1;
            field_start = p + 1;
          end
        end
      end
      byte_pos = p + 1;
    end
    if (!last) return 1'b0;
    n = eff_len();
    if (byte_pos <= n) begin
      res.verdict = prefix_ok ? VERDICT_PARTIAL : VERDICT_NONE;
    end else if (field_hit) begin
      res.value_offset = 12'(field_start);
      if (term_hit) begin
        res.verdict      = VERDICT_FOUND;
        res.value_length = 12'(field_len);
      end else begin
        res.verdict = VERDICT_PARTIAL;
      end
    end
    res.truncated = over_limit;
    clear_scan();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_verdict(input hfl_result_t got);
    hfl_result_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("result transfer with nothing pending: %h", got));
    end else begin
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict)
        report_mismatch($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
      if (got.value_offset !== want.value_offset)
        report_mismatch($sformatf("value_offset %0d, want %0d",
                                  got.value_offset, want.value_offset));
      if (got.value_length !== want.value_length)
        report_mismatch($sformatf("value_length %0d, want %0d",
                                  got.value_length, want.value_length));
      if (got.truncated !== want.truncated)
        report_mismatch($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic push_byte(input byte_t b, input logic last, input logic typed,
                           input hfl_result_t want);
    hfl_result_t predicted;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (scan_byte(b, last, predicted)) pending_verdicts.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Holds the input off until every pending verdict has been transferred.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_PATTERN_BYTES:   cfg_pattern = value;
      CFG_PATTERN_LENGTH:  cfg_len     = value[3:0];
      CFG_TERMINATOR_BYTE: cfg_term    = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 5))
      0, 1:    return byte_t'($urandom_range(0, 255));
      2:       return CHAR_CR;
      3:       return CHAR_LF;
      4:       return cfg_term;
      default: return pat_char($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [63:0] text_pattern();
    logic [63:0] p;
    for (int q = 0; q < 8; q++) begin
      p[8*q +: 8] = $urandom_range(0, 1) ? byte_t'($urandom_range(8'h41, 8'h5A))
                                         : byte_t'($urandom_range(8'h61, 8'h7A));
    end
    return p;
  endfunction

  task automatic push_crlf2();
    frame_bytes.push_back(CHAR_CR);
    frame_bytes.push_back(CHAR_LF);
    frame_bytes.push_back(CHAR_CR);
    frame_bytes.push_back(CHAR_LF);
  endtask

  // Fills frame_bytes with one payload: mostly a header line with the pattern and a value,
  // otherwise a short case-folded prefix of the pattern or plain noise.
  task automatic build_payload();
    int kind;
    int n;
    int bad;
    byte_t c;
    frame_bytes.delete();
    kind = $urandom_range(0, 9);
    n    = eff_len();
    if (kind <= 5) begin
      repeat ($urandom_range(0, 8)) frame_bytes.push_back(pick_byte());
      if ($urandom_range(0, 4) == 0) push_crlf2();
      bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int q = 0; q < n; q++) begin
        frame_bytes.push_back(q == bad ? byte_t'($urandom_range(0, 255)) : pat_char(q));
      end
      repeat ($urandom_range(0, 8)) frame_bytes.push_back(byte_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) frame_bytes.push_back(cfg_term);
      if ($urandom_range(0, 2) == 0) push_crlf2();
      repeat ($urandom_range(0, 6)) frame_bytes.push_back(pick_byte());
    end else if (kind == 6) begin
      for (int q = 0; q < $urandom_range(1, n); q++) begin
        c = pat_char(q);
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) c ^= 8'h20;
        if ($urandom_range(0, 9) == 0) c = byte_t'($urandom_range(0, 255));
        frame_bytes.push_back(c);
      end
    end else begin
      repeat ($urandom_range(1, 16)) frame_bytes.push_back(pick_byte());
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= stall_pat[ready_tick];
    ready_tick <= ready_tick + 4'd1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_tvalid && out_tready) check_verdict(hfl_result_t'(out_tdata[26:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] pat;
    logic [3:0]  len;
    byte_t       term;
    logic [2:0]  mask;
    int          phase;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_PATTERN_BYTES;
    cfg_wdata   = '0;
    stall_pat   = 16'hFFFF;
    ready_tick  = 4'd0;
    mismatches  = 0;
    burst_left  = 0;
    cfg_pattern = 64'h0;
    cfg_len     = 4'd6;
    cfg_term    = 8'h0D;
    clear_scan();

    // Pattern "Host: " is H,o,s,t,':',' ' from the lowest byte up.
    directed_rows = '{
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h00, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, VERDICT_PARTIAL}},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'hFF, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, VERDICT_NONE}},
      '{1'b1, CFG_PATTERN_BYTES,   64'h0000_203A_7473_6F48, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, CFG_TERMINATOR_BYTE, 64'h0D, 8'h00, 1'b0, 1'b0, '0},
      // Short payload that matches the pattern start only when case is ignored.
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h68, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h4F, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h53, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h54, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, VERDICT_PARTIAL}},
      // Field found with a two-byte value before the terminator.
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h48, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h6F, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h73, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h74, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h3A, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h20, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h61, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h62, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0D, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0A, 1'b1, 1'b1, '{1'b0, 12'd2, 12'd6, VERDICT_FOUND}},
      // Match whose terminator never arrives.
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h48, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h6F, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h73, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h74, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h3A, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h20, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h78, 1'b1, 1'b0, '0},
      // Length zero saturates to one; a pattern after the header end does not count.
      '{1'b1, CFG_PATTERN_LENGTH,  64'h0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0D, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0A, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0D, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h0A, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PATTERN_BYTES,   64'h0, 8'h48, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, VERDICT_NONE}}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    random_bytes = 0;
    phase        = 0;
    while (random_bytes < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: begin
          pat  = '1;
          len  = 4'd15;
          term = 8'hFF;
        end
        1: begin
          pat  = '0;
          len  = 4'd0;
          term = 8'h00;
        end
        2: begin
          pat  = text_pattern();
          len  = 4'd8;
          term = CHAR_CR;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       pat = {$urandom, $urandom};
            1:       pat = '1;
            default: pat = text_pattern();
          endcase
          len  = ($urandom_range(0, 2) == 0) ? LEN_EDGES[$urandom_range(0, 3)]
                                             : 4'($urandom_range(0, 15));
          term = ($urandom_range(0, 2) == 0) ? CHAR_CR : byte_t'($urandom_range(0, 255));
        end
      endcase
      mask = (phase < 3) ? 3'b111 : 3'($urandom_range(1, 7));
      // Unused upper bits of the narrow registers carry random values.
      if (mask[0]) write_reg(CFG_PATTERN_BYTES, pat);
      if (mask[1]) write_reg(CFG_PATTERN_LENGTH, {$urandom, $urandom_range(0, 15) << 4} | len);
      if (mask[2]) write_reg(CFG_TERMINATOR_BYTE, {$urandom, $urandom_range(0, 255) << 8} | term);

      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      if (stall_pat == 16'h0000) stall_pat = 16'h0001;

      repeat ($urandom_range(4, 12)) begin
        build_payload();
        random_bytes += frame_bytes.size();
        send_frame();
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/hfl_pkg.sv
hdl/hfl_scan.sv
hdl/http_header_field_locator.sv
verif/tb_http_header_field_locator.sv
